// File: sv/assert_macros.svh
// Assertion macros shared by the buddy allocator RTL.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, checked outside reset.
`define BBA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
// Next-cycle implication, checked outside reset.
`define BBA_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define BBA_ASSERT_IMP(lbl, ante, cons)
`define BBA_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// File: sv/bba_pkg.sv
// Package for the buddy block allocator: sizes, word types, commands, status codes.
// No dependencies.
`default_nettype none
package bba_pkg;
    localparam int LEVELS       = 10;
    localparam int UNIT_SHIFT   = 5;
    localparam int HEADER_BYTES = 32;

    localparam int ORD_W        = 4;
    localparam int TREE_W       = LEVELS + 1;
    localparam int TREE_NODES   = 2 << LEVELS;
    localparam int UNIT_W       = LEVELS;
    localparam int POOL_UNITS   = 1 << LEVELS;
    localparam int CNT_W        = LEVELS + 1;
    localparam int PB_W         = LEVELS + UNIT_SHIFT;
    localparam longint unsigned POOL_BYTES = 64'(1) << PB_W;
    localparam int REQ_W        = 32;
    localparam int NEED_W       = REQ_W + 1;
    localparam int OFF_W        = 15;
    localparam int BYTE_W       = 16;
    localparam int STAT_W       = 2;
    localparam int OSTORE_W     = 5;
    localparam int CMD_W        = 4;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_ZERO  = 2'd1;
    localparam logic [STAT_W-1:0] ST_SPACE = 2'd2;
    localparam logic [STAT_W-1:0] ST_BAD   = 2'd3;

    localparam logic [CMD_W-1:0] CMD_NONE       = 4'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR      = 4'd1;
    localparam logic [CMD_W-1:0] CMD_LOAD       = 4'd2;
    localparam logic [CMD_W-1:0] CMD_ORDER      = 4'd3;
    localparam logic [CMD_W-1:0] CMD_FIND_NEXT  = 4'd4;
    localparam logic [CMD_W-1:0] CMD_SCAN_START = 4'd5;
    localparam logic [CMD_W-1:0] CMD_SCAN_NEXT  = 4'd6;
    localparam logic [CMD_W-1:0] CMD_TAKE       = 4'd7;
    localparam logic [CMD_W-1:0] CMD_SPLIT      = 4'd8;
    localparam logic [CMD_W-1:0] CMD_ALLOC_DONE = 4'd9;
    localparam logic [CMD_W-1:0] CMD_REL_READ   = 4'd10;
    localparam logic [CMD_W-1:0] CMD_REL_COMMIT = 4'd11;
    localparam logic [CMD_W-1:0] CMD_MERGE      = 4'd12;
    localparam logic [CMD_W-1:0] CMD_REL_DONE   = 4'd13;
    localparam logic [CMD_W-1:0] CMD_ERR_DONE   = 4'd14;

    typedef struct packed {
        logic              op;
        logic [REQ_W-1:0]  request_bytes;
        logic [OFF_W-1:0]  release_offset;
    } in_word_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [OFF_W-1:0]  grant_offset;
        logic [ORD_W-1:0]  granted_order;
        logic [CNT_W-1:0]  live_blocks;
        logic [BYTE_W-1:0] bytes_in_use;
        logic [BYTE_W-1:0] free_bytes;
    } out_word_t;

    typedef struct packed {
        logic [CMD_W-1:0]  code;
        logic [STAT_W-1:0] err;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
        logic is_release;
        logic zero_req;
        logic oversize;
        logic order_has_free;
        logic order_at_top;
        logic order_above_want;
        logic tree_hit;
        logic rel_bad;
        logic can_merge;
        logic out_free;
    } dp_stat_t;
endpackage
`default_nettype wire

// File: sv/bba_ctrl.sv
// Controller state machine for the buddy block allocator.
// Depends on bba_pkg; drives commands into bba_datapath.
`default_nettype none
module bba_ctrl
    import bba_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  dp_stat_t stat,
    output cmd_t     cmd
);
    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_DECODE = 4'd2;
    localparam logic [3:0] S_FIND   = 4'd3;
    localparam logic [3:0] S_SCAN   = 4'd4;
    localparam logic [3:0] S_SPLIT  = 4'd5;
    localparam logic [3:0] S_RCHECK = 4'd6;
    localparam logic [3:0] S_MERGE  = 4'd7;
    localparam logic [3:0] S_ERR    = 4'd8;

    logic [3:0]        state_reg, state_next;
    logic [STAT_W-1:0] err_reg, err_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            err_reg   <= ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            err_reg   <= err_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        err_next   = err_reg;
        cmd.code   = CMD_NONE;
        cmd.err    = err_reg;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.code = CMD_CLEAR;
                if (stat.clear_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.code   = CMD_LOAD;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (stat.is_release)
                begin
                    cmd.code   = CMD_REL_READ;
                    state_next = S_RCHECK;
                end
                else if (stat.zero_req)
                begin
                    err_next   = ST_ZERO;
                    state_next = S_ERR;
                end
                else if (stat.oversize)
                begin
                    err_next   = ST_SPACE;
                    state_next = S_ERR;
                end
                else
                begin
                    cmd.code   = CMD_ORDER;
                    state_next = S_FIND;
                end
            end
            S_FIND:
            begin
                if (stat.order_has_free)
                begin
                    cmd.code   = CMD_SCAN_START;
                    state_next = S_SCAN;
                end
                else if (stat.order_at_top)
                begin
                    err_next   = ST_SPACE;
                    state_next = S_ERR;
                end
                else
                    cmd.code = CMD_FIND_NEXT;
            end
            S_SCAN:
            begin
                if (stat.tree_hit)
                begin
                    cmd.code   = CMD_TAKE;
                    state_next = S_SPLIT;
                end
                else
                    cmd.code = CMD_SCAN_NEXT;
            end
            S_SPLIT:
            begin
                if (stat.order_above_want)
                    cmd.code = CMD_SPLIT;
                else if (stat.out_free)
                begin
                    cmd.code   = CMD_ALLOC_DONE;
                    state_next = S_IDLE;
                end
            end
            S_RCHECK:
            begin
                if (stat.rel_bad)
                begin
                    err_next   = ST_BAD;
                    state_next = S_ERR;
                end
                else
                begin
                    cmd.code   = CMD_REL_COMMIT;
                    state_next = S_MERGE;
                end
            end
            S_MERGE:
            begin
                if (stat.can_merge)
                    cmd.code = CMD_MERGE;
                else if (stat.out_free)
                begin
                    cmd.code   = CMD_REL_DONE;
                    state_next = S_IDLE;
                end
            end
            S_ERR:
            begin
                if (stat.out_free)
                begin
                    cmd.code   = CMD_ERR_DONE;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    assign in_stall = (state_reg != S_IDLE);
endmodule
`default_nettype wire

// File: sv/bba_datapath.sv
// Datapath for the buddy block allocator: tree, order and size memories, counters,
// result register. Depends on bba_pkg and assert_macros.svh; driven by bba_ctrl.
`default_nettype none
`include "assert_macros.svh"
module bba_datapath
    import bba_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  in_word_t  in_data,
    input  cmd_t      cmd,
    output dp_stat_t  stat,
    input  logic      out_stall,
    output logic      out_valid,
    output out_word_t out_data
);
    localparam int FREE_W = CNT_W + 13;

    // memories
    logic                tree_mem [0:TREE_NODES-1];
    logic [OSTORE_W-1:0] ord_mem  [0:POOL_UNITS-1];
    logic [BYTE_W-1:0]   byt_mem  [0:POOL_UNITS-1];

    // request and walk registers
    logic                op_reg;
    logic [REQ_W-1:0]    req_reg;
    logic [OFF_W-1:0]    off_reg;
    logic [NEED_W-1:0]   need_reg;
    logic [ORD_W-1:0]    want_reg, want_next;
    logic [ORD_W-1:0]    o_reg, o_next;
    logic [TREE_W-1:0]   node_reg, node_next;
    logic [UNIT_W-1:0]   unit_reg, unit_next;
    logic                bad_reg, bad_next;
    logic                tree_rd_reg;
    logic [OSTORE_W-1:0] ord_rd_reg;
    logic [BYTE_W-1:0]   byt_rd_reg;

    // statistics and control
    logic [CNT_W-1:0]    fcnt_reg [0:LEVELS];
    logic [CNT_W-1:0]    fb_reg, fb_next;
    logic [CNT_W-1:0]    fu_reg, fu_next;
    logic [CNT_W-1:0]    live_reg, live_next;
    logic [BYTE_W-1:0]   total_reg, total_next;
    logic [TREE_W-1:0]   clr_reg, clr_next;
    logic                out_valid_reg;
    out_word_t           out_reg;

    // port controls
    logic                tree_we, tree_wd, tree_re;
    logic [TREE_W-1:0]   tree_wa, tree_ra;
    logic                ord_we, ord_re, byt_we;
    logic [UNIT_W-1:0]   ord_wa, ord_ra;
    logic [OSTORE_W-1:0] ord_wd;
    logic                fcnt_inc, fcnt_dec;
    logic [ORD_W-1:0]    fcnt_idx;
    logic                emit, out_free;
    logic [STAT_W-1:0]   res_status;
    logic [OFF_W-1:0]    res_offset;
    logic [ORD_W-1:0]    res_order;

    // helpers
    logic [NEED_W-1:0]   need_m1;
    logic [ORD_W-1:0]    want_c, o_rel;
    logic [TREE_W-1:0]   node_rel, level_base, node_sh;
    logic [UNIT_W-1:0]   unit_alloc;
    logic [OFF_W-1:0]    off_b, unit_full;
    logic [FREE_W-1:0]   free_space, headers, free_calc;

    function automatic logic [ORD_W-1:0] order_of(input logic [PB_W-1:0] m);
        int bl;
        bl = 0;
        for (int i = 0; i < PB_W; i++)
        begin
            if (m[i])
                bl = i + 1;
        end
        if (bl > UNIT_SHIFT)
            return ORD_W'(bl - UNIT_SHIFT);
        return '0;
    endfunction

    assign need_m1    = need_reg - NEED_W'(1);
    assign want_c     = order_of(need_m1[PB_W-1:0]);
    assign level_base = TREE_W'(1) << (ORD_W'(LEVELS) - o_reg);
    assign node_sh    = (node_reg - level_base) << o_reg;
    assign unit_alloc = node_sh[UNIT_W-1:0];
    assign o_rel      = ORD_W'(ord_rd_reg - OSTORE_W'(1));
    assign node_rel   = (TREE_W'(1) << (ORD_W'(LEVELS) - o_rel)) + (TREE_W'(unit_reg) >> o_rel);
    assign off_b      = off_reg - OFF_W'(HEADER_BYTES);
    assign unit_full  = off_b >> UNIT_SHIFT;
    assign out_free   = !out_valid_reg || !out_stall;

    always_comb
    begin
        want_next  = want_reg;
        o_next     = o_reg;
        node_next  = node_reg;
        unit_next  = unit_reg;
        bad_next   = bad_reg;
        fb_next    = fb_reg;
        fu_next    = fu_reg;
        live_next  = live_reg;
        total_next = total_reg;
        clr_next   = clr_reg;
        tree_we    = 1'b0;
        tree_wa    = node_reg;
        tree_wd    = 1'b0;
        tree_re    = 1'b0;
        tree_ra    = node_reg;
        ord_we     = 1'b0;
        ord_wa     = unit_reg;
        ord_wd     = '0;
        ord_re     = 1'b0;
        ord_ra     = unit_reg;
        byt_we     = 1'b0;
        fcnt_inc   = 1'b0;
        fcnt_dec   = 1'b0;
        fcnt_idx   = o_reg;
        emit       = 1'b0;
        res_status = ST_OK;
        res_offset = '0;
        res_order  = '0;
        case (cmd.code)
            CMD_CLEAR:
            begin
                // sweep: only the root starts free, no block starts anywhere
                tree_we  = 1'b1;
                tree_wa  = clr_reg;
                tree_wd  = (clr_reg == TREE_W'(1));
                ord_we   = !clr_reg[LEVELS];
                ord_wa   = clr_reg[UNIT_W-1:0];
                clr_next = clr_reg + TREE_W'(1);
            end
            CMD_ORDER:
            begin
                want_next = want_c;
                o_next    = want_c;
            end
            CMD_FIND_NEXT:
                o_next = o_reg + ORD_W'(1);
            CMD_SCAN_START:
            begin
                node_next = level_base;
                tree_re   = 1'b1;
                tree_ra   = level_base;
            end
            CMD_SCAN_NEXT:
            begin
                node_next = node_reg + TREE_W'(1);
                tree_re   = 1'b1;
                tree_ra   = node_reg + TREE_W'(1);
            end
            CMD_TAKE:
            begin
                tree_we  = 1'b1;
                tree_wa  = node_reg;
                fcnt_dec = 1'b1;
                fb_next  = fb_reg - CNT_W'(1);
            end
            CMD_SPLIT:
            begin
                // keep the lower half, free the upper half
                o_next    = o_reg - ORD_W'(1);
                node_next = node_reg << 1;
                tree_we   = 1'b1;
                tree_wa   = (node_reg << 1) | TREE_W'(1);
                tree_wd   = 1'b1;
                fcnt_inc  = 1'b1;
                fcnt_idx  = o_reg - ORD_W'(1);
                fb_next   = fb_reg + CNT_W'(1);
            end
            CMD_ALLOC_DONE:
            begin
                ord_we     = 1'b1;
                ord_wa     = unit_alloc;
                ord_wd     = OSTORE_W'(o_reg) + OSTORE_W'(1);
                byt_we     = 1'b1;
                live_next  = live_reg + CNT_W'(1);
                total_next = total_reg + req_reg[BYTE_W-1:0];
                fu_next    = fu_reg - (CNT_W'(1) << o_reg);
                emit       = 1'b1;
                res_offset = OFF_W'({unit_alloc, {UNIT_SHIFT{1'b0}}}) + OFF_W'(HEADER_BYTES);
                res_order  = o_reg;
            end
            CMD_REL_READ:
            begin
                bad_next  = (off_reg < OFF_W'(HEADER_BYTES))
                          || (off_b[UNIT_SHIFT-1:0] != '0)
                          || (32'(unit_full) >= 32'(POOL_UNITS));
                unit_next = unit_full[UNIT_W-1:0];
                ord_re    = 1'b1;
                ord_ra    = unit_full[UNIT_W-1:0];
            end
            CMD_REL_COMMIT:
            begin
                o_next     = o_rel;
                node_next  = node_rel;
                ord_we     = 1'b1;
                ord_wa     = unit_reg;
                live_next  = live_reg - CNT_W'(1);
                total_next = (total_reg >= byt_rd_reg) ? total_reg - byt_rd_reg : '0;
                fu_next    = fu_reg + (CNT_W'(1) << o_rel);
                tree_re    = 1'b1;
                tree_ra    = node_rel ^ TREE_W'(1);
            end
            CMD_MERGE:
            begin
                // absorb the free buddy and move up one order
                tree_we   = 1'b1;
                tree_wa   = node_reg ^ TREE_W'(1);
                fcnt_dec  = 1'b1;
                fb_next   = fb_reg - CNT_W'(1);
                o_next    = o_reg + ORD_W'(1);
                node_next = node_reg >> 1;
                tree_re   = 1'b1;
                tree_ra   = (node_reg >> 1) ^ TREE_W'(1);
            end
            CMD_REL_DONE:
            begin
                tree_we   = 1'b1;
                tree_wa   = node_reg;
                tree_wd   = 1'b1;
                fcnt_inc  = 1'b1;
                fb_next   = fb_reg + CNT_W'(1);
                emit      = 1'b1;
                res_order = o_reg;
            end
            CMD_ERR_DONE:
            begin
                emit       = 1'b1;
                res_status = cmd.err;
            end
            default:
            begin
            end
        endcase
    end

    assign free_space = FREE_W'(fu_next) << UNIT_SHIFT;
    assign headers    = FREE_W'(fb_next) * FREE_W'(HEADER_BYTES);
    assign free_calc  = (free_space >= headers) ? free_space - headers : '0;

    always_ff @(posedge clk)
    begin
        if (tree_we)
            tree_mem[tree_wa] <= tree_wd;
        if (tree_re)
            tree_rd_reg <= tree_mem[tree_ra];
    end

    always_ff @(posedge clk)
    begin
        if (ord_we)
            ord_mem[ord_wa] <= ord_wd;
        if (byt_we)
            byt_mem[unit_alloc] <= req_reg[BYTE_W-1:0];
        if (ord_re)
        begin
            ord_rd_reg <= ord_mem[ord_ra];
            byt_rd_reg <= byt_mem[ord_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.code == CMD_LOAD)
        begin
            op_reg   <= in_data.op;
            req_reg  <= in_data.request_bytes;
            off_reg  <= in_data.release_offset;
            need_reg <= NEED_W'(in_data.request_bytes) + NEED_W'(HEADER_BYTES);
        end
        want_reg <= want_next;
        o_reg    <= o_next;
        node_reg <= node_next;
        unit_reg <= unit_next;
        bad_reg  <= bad_next;
        if (emit)
        begin
            out_reg.status        <= res_status;
            out_reg.grant_offset  <= res_offset;
            out_reg.granted_order <= res_order;
            out_reg.live_blocks   <= live_next;
            out_reg.bytes_in_use  <= total_next;
            out_reg.free_bytes    <= free_calc[BYTE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= LEVELS; i++)
                fcnt_reg[i] <= (i == LEVELS) ? CNT_W'(1) : '0;
            fb_reg        <= CNT_W'(1);
            fu_reg        <= CNT_W'(POOL_UNITS);
            live_reg      <= '0;
            total_reg     <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (fcnt_inc)
                fcnt_reg[fcnt_idx] <= fcnt_reg[fcnt_idx] + CNT_W'(1);
            else if (fcnt_dec)
                fcnt_reg[fcnt_idx] <= fcnt_reg[fcnt_idx] - CNT_W'(1);
            fb_reg        <= fb_next;
            fu_reg        <= fu_next;
            live_reg      <= live_next;
            total_reg     <= total_next;
            clr_reg       <= clr_next;
            out_valid_reg <= emit || (out_valid_reg && out_stall);
        end
    end

    assign stat.clear_last       = &clr_reg;
    assign stat.is_release       = op_reg;
    assign stat.zero_req         = (req_reg == '0);
    assign stat.oversize         = (64'(need_reg) > POOL_BYTES);
    assign stat.order_has_free   = (fcnt_reg[o_reg] != '0);
    assign stat.order_at_top     = (o_reg == ORD_W'(LEVELS));
    assign stat.order_above_want = (o_reg > want_reg);
    assign stat.tree_hit         = tree_rd_reg;
    assign stat.rel_bad          = bad_reg || (ord_rd_reg == '0);
    assign stat.can_merge        = (o_reg < ORD_W'(LEVELS)) && tree_rd_reg;
    assign stat.out_free         = out_free;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    `BBA_ASSERT_IMP(a_emit_room, cmd.code == CMD_ALLOC_DONE || cmd.code == CMD_REL_DONE || cmd.code == CMD_ERR_DONE, out_free)
    `BBA_ASSERT_IMP(a_units_range, 1'b1, fu_reg <= CNT_W'(POOL_UNITS))
    `BBA_ASSERT_IMP(a_empty_total, live_reg == '0, total_reg == '0)
    `BBA_ASSERT_NXT(a_take_count, cmd.code == CMD_TAKE, fb_reg == $past(fb_reg) - CNT_W'(1))
endmodule
`default_nettype wire

// File: sv/buddy_block_allocator_core.sv
// Buddy block allocator, top level: controller plus datapath.
// Depends on bba_pkg, bba_ctrl and bba_datapath.
//
//   Input channel in_valid / in_stall / in_data carries one request word:
//   op 0 allocates request_bytes (plus a header), op 1 releases the block
//   at release_offset. Each request gives exactly one result word on
//   out_valid / out_stall / out_data with status, grant offset, order and
//   the pool statistics taken after the request.
//   Requests are handled one at a time; the next word is taken the cycle
//   after the result is written. An allocate steps up through the orders,
//   scans the tree nodes at the chosen order (1 to 2^(LEVELS-order) of
//   them, one tree memory read per cycle), then splits by halving; a
//   release makes its buddy merges, one merge per tree memory read. Zero
//   size, oversize, bad release and no space give an error status.
//   The result sits in an output register; a new request is accepted while
//   it waits, only the next result waits on out_stall, and a stalled word
//   holds unchanged until taken. After reset a clearing pass sweeps the
//   tree and block-order memories.
`default_nettype none
module buddy_block_allocator_core
    import bba_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_word_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output out_word_t out_data
);
    cmd_t     cmd;
    dp_stat_t stat;

    // sequence each request's walk over the tree; in_stall stays high
    // through the clearing pass
    bba_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    // hold memories, counters and the result register
    bba_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_data  (out_data)
    );
endmodule
`default_nettype wire

// File: tb/tb_buddy_block_allocator_core.sv
// Testbench for buddy_block_allocator_core: directed and random allocate/release words
// checked against an in-bench buddy predictor. Depends on bba_pkg and the core RTL.
`timescale 1ns / 1ps
`default_nettype none
module tb_buddy_block_allocator_core
    import bba_pkg::*;
();

    localparam int WATCH_LIMIT = 40000;
    localparam int UNIT_BYTES  = 1 << UNIT_SHIFT;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    in_word_t  in_data;
    logic      out_valid;
    logic      out_stall;
    out_word_t out_data;

    buddy_block_allocator_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // 4 ns clock
    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // Predictor state: a mirror of the allocator's tree and block tables.
    logic        pool_free_node [TREE_NODES];
    logic [4:0]  pool_start_order [POOL_UNITS];
    longint unsigned pool_user_bytes [POOL_UNITS];
    longint unsigned pool_live, pool_req_total, pool_free_units, pool_free_blocks;

    out_word_t expected_words [$];
    int        granted_offsets [$];   // user offsets currently held
    int        mismatch_count;
    int        words_sent, words_taken;
    int        idle_pct_in, idle_pct_out;
    int        idle_cycles;

    function automatic void pool_reset();
        for (int i = 0; i < TREE_NODES; i++) pool_free_node[i] = 1'b0;
        for (int i = 0; i < POOL_UNITS; i++)
        begin
            pool_start_order[i] = '0;
            pool_user_bytes[i]  = 0;
        end
        pool_free_node[1] = 1'b1;
        pool_live = 0;
        pool_req_total = 0;
        pool_free_units = POOL_UNITS;
        pool_free_blocks = 1;
    endfunction

    function automatic out_word_t pool_word(logic [STAT_W-1:0] st, longint unsigned off,
                                            longint unsigned ord);
        out_word_t w;
        longint unsigned space, hdrs;
        space = pool_free_units * UNIT_BYTES;
        hdrs  = pool_free_blocks * HEADER_BYTES;
        w.status        = st;
        w.grant_offset  = off[OFF_W-1:0];
        w.granted_order = ord[ORD_W-1:0];
        w.live_blocks   = pool_live[CNT_W-1:0];
        w.bytes_in_use  = pool_req_total[BYTE_W-1:0];
        w.free_bytes    = (space >= hdrs) ? BYTE_W'(space - hdrs) : '0;
        return w;
    endfunction

    // Compute the result of one request and advance the predictor.
    function automatic out_word_t pool_apply(in_word_t w);
        longint unsigned need, want, o, n, u, b;
        bit found;
        found = 0;
        n = 0;
        if (!w.op)
        begin
            if (w.request_bytes == 0) return pool_word(ST_ZERO, 0, 0);
            need = longint'(w.request_bytes) + HEADER_BYTES;
            want = 0;
            while (want <= LEVELS && (longint'(UNIT_BYTES) << want) < need) want++;
            if (want > LEVELS) return pool_word(ST_SPACE, 0, 0);
            for (o = want; o <= LEVELS; o++)
            begin
                for (n = 1 << (LEVELS - o); n < (2 << (LEVELS - o)); n++)
                    if (pool_free_node[n])
                    begin
                        found = 1;
                        break;
                    end
                if (found) break;
            end
            if (!found) return pool_word(ST_SPACE, 0, 0);
            pool_free_node[n] = 1'b0;
            pool_free_blocks--;
            while (o > want)
            begin
                o--;
                n = n << 1;
                pool_free_node[n + 1] = 1'b1;
                pool_free_blocks++;
            end
            u = (n - (1 << (LEVELS - o))) << o;
            pool_start_order[u] = 5'(o + 1);
            pool_user_bytes[u] = w.request_bytes;
            pool_live++;
            pool_req_total += w.request_bytes;
            pool_free_units -= (1 << o);
            return pool_word(ST_OK, u * UNIT_BYTES + HEADER_BYTES, o);
        end
        if (w.release_offset < HEADER_BYTES) return pool_word(ST_BAD, 0, 0);
        b = w.release_offset - HEADER_BYTES;
        u = b >> UNIT_SHIFT;
        if ((b & (UNIT_BYTES - 1)) != 0 || u >= POOL_UNITS || pool_start_order[u] == 0)
            return pool_word(ST_BAD, 0, 0);
        o = pool_start_order[u] - 1;
        pool_start_order[u] = '0;
        pool_live--;
        pool_req_total = (pool_req_total >= pool_user_bytes[u]) ?
                         pool_req_total - pool_user_bytes[u] : 0;
        pool_user_bytes[u] = 0;
        pool_free_units += (1 << o);
        n = (1 << (LEVELS - o)) + (u >> o);
        while (o < LEVELS && pool_free_node[n ^ 1])
        begin
            pool_free_node[n ^ 1] = 1'b0;
            pool_free_blocks--;
            n >>= 1;
            o++;
        end
        pool_free_node[n] = 1'b1;
        pool_free_blocks++;
        return pool_word(ST_OK, 0, o);
    endfunction

    task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
        $display("MISMATCH word %0d %s: got %0d expected %0d", words_taken, what, got, want);
        mismatch_count++;
    endtask

    // Result checker: sample at the rising edge, compare with the oldest expectation.
    always @(posedge clk)
    begin
        out_word_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_words.size() == 0)
                report_mismatch("unexpected word", 1, 0);
            else
            begin
                e = expected_words.pop_front();
                if (out_data.status !== e.status)
                    report_mismatch("status", out_data.status, e.status);
                if (out_data.grant_offset !== e.grant_offset)
                    report_mismatch("grant_offset", out_data.grant_offset, e.grant_offset);
                if (out_data.granted_order !== e.granted_order)
                    report_mismatch("granted_order", out_data.granted_order, e.granted_order);
                if (out_data.live_blocks !== e.live_blocks)
                    report_mismatch("live_blocks", out_data.live_blocks, e.live_blocks);
                if (out_data.bytes_in_use !== e.bytes_in_use)
                    report_mismatch("bytes_in_use", out_data.bytes_in_use, e.bytes_in_use);
                if (out_data.free_bytes !== e.free_bytes)
                    report_mismatch("free_bytes", out_data.free_bytes, e.free_bytes);
            end
            words_taken++;
        end
    end

    // Watchdog: count cycles with no word accepted on either side.
    always @(posedge clk)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCH_LIMIT)
        begin
            $display("watchdog: no progress for %0d cycles", WATCH_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Receiver stalls at random, re-drawn every falling edge.
    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < idle_pct_out);
    end

    // Send one word; idle first at random, then hold it until accepted.
    // Valid stays high on return so back-to-back words leave no gap.
    task automatic send_word(in_word_t w);
        out_word_t e;
        while ($urandom_range(99) < idle_pct_in)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_data  <= w;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        e = pool_apply(w);
        expected_words.push_back(e);
        if (!w.op && e.status == ST_OK)
            granted_offsets.push_back(e.grant_offset);
        words_sent++;
        @(negedge clk);
    endtask

    function automatic in_word_t alloc_word(logic [31:0] bytes);
        in_word_t w;
        w.op = 1'b0;
        w.request_bytes = bytes;
        w.release_offset = 15'($urandom);
        return w;
    endfunction

    function automatic in_word_t release_word(logic [14:0] off);
        in_word_t w;
        w.op = 1'b1;
        w.request_bytes = $urandom;
        w.release_offset = off;
        return w;
    endfunction

    // Release a held block chosen at random.
    task automatic release_held();
        int k;
        int off;
        k = $urandom_range(granted_offsets.size() - 1);
        off = granted_offsets[k];
        granted_offsets.delete(k);
        send_word(release_word(15'(off)));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (expected_words.size() != 0) @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    // Directed corners: size extremes, whole-pool grant, errors, double release.
    task automatic test_directed();
        send_word(alloc_word(32'd0));
        send_word(alloc_word(32'hFFFF_FFFF));
        send_word(alloc_word(32'd32737));                 // one byte over the pool
        send_word(alloc_word(32'd32736));                 // whole pool
        send_word(alloc_word(32'd1));                     // no space left
        send_word(release_word(15'd32));
        send_word(release_word(15'd32));                  // double release
        granted_offsets.delete();
        send_word(release_word(15'd0));                   // under the header
        send_word(release_word(15'd33));                  // off unit boundary
        send_word(release_word(15'h7FFF));                // off unit boundary, top of the offset range
        send_word(release_word(15'h7FE0));
        send_word(alloc_word(32'd1));                     // smallest grant, order 1, split from the root
        send_word(alloc_word(32'd33));
        send_word(alloc_word(32'd96));
        send_word(alloc_word(32'hAAAA_5555));
        send_word(alloc_word(32'h0000_5AA5));
        send_word(release_word(15'h5555));
        send_word(release_word(15'h2AAA));
        while (granted_offsets.size() != 0) release_held();
        drain();
    endtask

    // Random mix: mostly well-formed alloc/release traffic, some noise.
    task automatic test_random(int count, int in_pct, int out_pct);
        int r;
        idle_pct_in  = in_pct;
        idle_pct_out = out_pct;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(99);
            if (r < 45 || granted_offsets.size() == 0)
            begin
                case ($urandom_range(9))
                    0: send_word(alloc_word($urandom));
                    1: send_word(alloc_word($urandom_range(8192, 1)));
                    default: send_word(alloc_word($urandom_range(500, 1)));
                endcase
            end
            else if (r < 90)
                release_held();
            else if (r < 95)
                send_word(release_word(15'($urandom)));
            else
                send_word(alloc_word(32'd0));
        end
        // Hold off until the pipeline is empty, then return the pool.
        drain();
        while (granted_offsets.size() != 0) release_held();
        drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        idle_pct_in = 0;
        idle_pct_out = 0;
        idle_cycles = 0;
        mismatch_count = 0;
        words_sent = 0;
        words_taken = 0;
        pool_reset();
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random(160, 0, 0);
        test_random(160, 63, 0);
        test_random(160, 0, 63);
        test_random(160, 14, 14);

        $display("Covered %0d requests (%0d results): size and offset corners, splits,",
                 words_sent, words_taken);
        $display("merges, double release, and random traffic under four idle mixes.");
        if (mismatch_count == 0 && expected_words.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
`default_nettype wire
